### rtl/core/adeq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adeq_pkg
// shared types and constants for the array double-ended queue
// ----------------------------------------------------------------------------
package adeq_pkg;

  localparam int DEPTH  = 128;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int WORD_W = 32;

  localparam logic [IDX_W-1:0] FIRST_IDX = '0;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

  // operation codes
  localparam logic [1:0] FN_INS_FRONT = 2'd0;
  localparam logic [1:0] FN_INS_REAR  = 2'd1;
  localparam logic [1:0] FN_REM_FRONT = 2'd2;
  localparam logic [1:0] FN_REM_REAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
  } mem_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       from_mem;
    logic       now_empty;
  } res_info_t;

endpackage

### rtl/core/array_double_ended_queue.sv
`timescale 1ns / 1ps
// a result is registered and is valid in the cycle after its item is accepted
// throughput: one item per cycle, sustained while the output is taken
// the single-port word store does at most one read or one write per item
// reset: synchronous; indices go to zero, the queue is marked empty and the
// result valid flag is cleared; the word store itself is not cleared
// ----------------------------------------------------------------------------
// array_double_ended_queue
// double-ended queue in a linear word store, with front and rear indices
// ----------------------------------------------------------------------------
module array_double_ended_queue (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic signed [31:0] value,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] data,
  output logic               now_empty
);

  adeq_pkg::mem_req_t  req;
  adeq_pkg::res_info_t info;
  logic                fire;
  logic [31:0]         rdata;

  // result stage
  logic                res_valid;
  logic [1:0]          res_status;
  logic [31:0]         res_word;
  logic                res_from_mem;
  logic                res_empty;

  // an item is taken whenever the result stage is free or drains this cycle
  assign in_ready = !res_valid || out_ready;
  assign fire     = in_valid && in_ready;

  // index bookkeeping and decode; state changes at the accepting edge
  adeq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .func (func),
    .req  (req),
    .info (info)
  );

  // the word store; a removal's read is registered in the store, in step with
  // the result stage. a read never meets a write in the same cycle, and a write
  // is seen by any later read, so no bypass is needed
  adeq_ram #(
    .WIDTH (adeq_pkg::WORD_W),
    .DEPTH (adeq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .re    (req.re),
    .addr  (req.addr),
    .wdata (value),
    .rdata (rdata)
  );

  // result register; read data stays put in the store's output register
  // while a result is held, since no new read is issued until it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_status   <= info.status;
      res_from_mem <= info.from_mem;
      res_empty    <= info.now_empty;
      // inserted word echoed on success, zero on any error
      res_word     <= (info.status == adeq_pkg::ST_DONE) ? value : '0;
    end
  end

  assign out_valid = res_valid;
  assign status    = res_status;
  assign data      = res_from_mem ? rdata : res_word;
  assign now_empty = res_empty;

endmodule

### rtl/core/adeq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adeq_ram
// single-port synchronous word store, registered read
// ----------------------------------------------------------------------------
module adeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/core/adeq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adeq_ctrl
// front/rear index keeping and per-item operation decode
// ----------------------------------------------------------------------------
module adeq_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  logic [1:0]              func,
  output adeq_pkg::mem_req_t      req,
  output adeq_pkg::res_info_t     info
);

  logic [adeq_pkg::IDX_W-1:0] head;
  logic [adeq_pkg::IDX_W-1:0] tail;
  logic                       empty;
  logic [adeq_pkg::IDX_W-1:0] head_next;
  logic [adeq_pkg::IDX_W-1:0] tail_next;
  logic                       empty_next;

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    empty_next     = empty;
    req.we         = 1'b0;
    req.re         = 1'b0;
    req.addr       = head;
    info.status    = adeq_pkg::ST_DONE;
    info.from_mem  = 1'b0;
    case (func)
      adeq_pkg::FN_INS_FRONT: begin
        if (empty) begin
          head_next  = adeq_pkg::FIRST_IDX;
          tail_next  = adeq_pkg::FIRST_IDX;
          empty_next = 1'b0;
          req.we     = 1'b1;
          req.addr   = adeq_pkg::FIRST_IDX;
        end else if (head == adeq_pkg::FIRST_IDX) begin
          info.status = adeq_pkg::ST_OVERFLOW;
        end else begin
          head_next = head - 1'b1;
          req.we    = 1'b1;
          req.addr  = head - 1'b1;
        end
      end
      adeq_pkg::FN_INS_REAR: begin
        if (empty) begin
          head_next  = adeq_pkg::FIRST_IDX;
          tail_next  = adeq_pkg::FIRST_IDX;
          empty_next = 1'b0;
          req.we     = 1'b1;
          req.addr   = adeq_pkg::FIRST_IDX;
        end else if (tail == adeq_pkg::LAST_IDX) begin
          info.status = adeq_pkg::ST_OVERFLOW;
        end else begin
          tail_next = tail + 1'b1;
          req.we    = 1'b1;
          req.addr  = tail + 1'b1;
        end
      end
      adeq_pkg::FN_REM_FRONT: begin
        if (empty) begin
          info.status = adeq_pkg::ST_UNDERFLOW;
        end else begin
          req.re        = 1'b1;
          req.addr      = head;
          info.from_mem = 1'b1;
          if (head == tail) begin
            empty_next = 1'b1;
            head_next  = adeq_pkg::FIRST_IDX;
            tail_next  = adeq_pkg::FIRST_IDX;
          end else begin
            head_next = head + 1'b1;
          end
        end
      end
      default: begin
        if (empty) begin
          info.status = adeq_pkg::ST_UNDERFLOW;
        end else begin
          req.re        = 1'b1;
          req.addr      = tail;
          info.from_mem = 1'b1;
          if (head == tail) begin
            empty_next = 1'b1;
            head_next  = adeq_pkg::FIRST_IDX;
            tail_next  = adeq_pkg::FIRST_IDX;
          end else begin
            tail_next = tail - 1'b1;
          end
        end
      end
    endcase
    info.now_empty = empty_next;
    // no access unless the item is taken this cycle
    req.we = req.we & fire;
    req.re = req.re & fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= adeq_pkg::FIRST_IDX;
      tail  <= adeq_pkg::FIRST_IDX;
      empty <= 1'b1;
    end else if (fire) begin
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
    end
  end

endmodule

### rtl/core/adeq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adeq_checker
// port-level checks on the double-ended queue, bound to the top level
// ----------------------------------------------------------------------------
module adeq_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic signed [31:0] data,
  input logic               now_empty
);

  // errors carry a zero word
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == adeq_pkg::ST_OVERFLOW || status == adeq_pkg::ST_UNDERFLOW)
      |-> data == 32'sd0)
    else $error("error result with nonzero data");

  // overflow only happens on a non-empty queue, which stays so
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == adeq_pkg::ST_OVERFLOW |-> !now_empty)
    else $error("overflow reported on empty queue");

  // underflow only happens on an empty queue
  a_udf_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == adeq_pkg::ST_UNDERFLOW |-> now_empty)
    else $error("underflow reported on non-empty queue");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data)
      && $stable(now_empty))
    else $error("stalled result changed");

endmodule

bind array_double_ended_queue adeq_checker u_adeq_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .data      (data),
  .now_empty (now_empty)
);
